FILE: src/mtep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and codes for the track-chunk parser: parser phases, event
// classes, status byte codes and the per-byte result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_CMD,
        PH_VOICE_DATA,
        PH_SKIP,
        PH_SYSEX_LEN,
        PH_META_TYPE,
        PH_META_LEN,
        PH_BULK_DATA,
        PH_ERROR
    } t_phase;

    localparam logic [1:0] CLASS_VOICE   = 2'd0;
    localparam logic [1:0] CLASS_RUNNING = 2'd1;
    localparam logic [1:0] CLASS_SYSEX   = 2'd2;
    localparam logic [1:0] CLASS_META    = 2'd3;

    localparam logic [2:0] CMD_PROGRAM  = 3'd5;
    localparam logic [2:0] CMD_PRESSURE = 3'd6;

    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_RT_FIRST  = 8'hF8;
    localparam logic [7:0] ST_RT_LAST   = 8'hFE;
    localparam logic [7:0] ST_META      = 8'hFF;

    localparam int OUT_LEN_BITS  = 28;
    localparam int OUT_TIME_BITS = 32;

    typedef struct packed {
        logic                     event_start;
        logic [1:0]               event_class;
        logic [3:0]               channel;
        logic [2:0]               voice_command;
        logic [7:0]               type_byte;
        logic [OUT_LEN_BITS-1:0]  declared_length;
        logic [OUT_TIME_BITS-1:0] event_time;
        logic                     data_valid;
        logic [7:0]               data_byte;
        logic                     data_last;
        logic                     parse_error;
    } t_result;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_time_ctl;

endpackage
`default_nettype wire

FILE: src/mtep_time_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser time unit
// Collects the variable-length delta time and keeps the absolute track time,
// both saturating to all ones.
// ----------------------------------------------------------------------------
module mtep_time_unit #(
    parameter int TIME_BITS = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  mtep_pkg::t_time_ctl                  i_ctl,
    input  wire  [7:0]                           i_track_byte,
    output logic [mtep_pkg::OUT_TIME_BITS-1:0]   o_event_time
);

    localparam int EXT_BITS = (TIME_BITS > mtep_pkg::OUT_TIME_BITS) ?
                              TIME_BITS : mtep_pkg::OUT_TIME_BITS;

    logic [TIME_BITS-1:0] r_delta;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_delta;
    logic [TIME_BITS-1:0] n_time;
    logic [TIME_BITS-1:0] w_push;
    logic [TIME_BITS:0]   w_sum;
    logic [EXT_BITS-1:0]  w_time_ext;

    always_comb begin
        if (|r_delta[TIME_BITS-1 -: 7]) begin
            w_push = '1;
        end else begin
            w_push = {r_delta[TIME_BITS-8:0], i_track_byte[6:0]};
        end
        w_sum   = {1'b0, r_time} + {1'b0, w_push};
        n_delta = r_delta;
        n_time  = r_time;
        if (i_ctl.clear) begin
            n_delta = '0;
            n_time  = '0;
        end else if (i_ctl.advance) begin
            if (i_track_byte[7]) begin
                n_delta = w_push;
            end else begin
                n_delta = '0;
                n_time  = w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_time  <= '0;
        end else begin
            r_delta <= n_delta;
            r_time  <= n_time;
        end
    end

    assign w_time_ext   = EXT_BITS'(r_time);
    assign o_event_time = w_time_ext[mtep_pkg::OUT_TIME_BITS-1:0];

endmodule
`default_nettype wire

FILE: src/mtep_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Phase state machine: status decode, running status, sysex and meta counts,
// data byte tracking and the sticky error. Builds one result per byte.
// ----------------------------------------------------------------------------
module mtep_core #(
    parameter int LEN_BITS = 28
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_step,
    input  wire                                 i_restart,
    input  wire  [7:0]                          i_track_byte,
    input  wire  [mtep_pkg::OUT_TIME_BITS-1:0]  i_event_time,
    output mtep_pkg::t_time_ctl                 o_time_ctl,
    output mtep_pkg::t_result                   o_result
);

    localparam int EXT_BITS = (LEN_BITS > mtep_pkg::OUT_LEN_BITS) ?
                              LEN_BITS : mtep_pkg::OUT_LEN_BITS;

    mtep_pkg::t_phase  r_phase,     n_phase;
    logic [2:0]        r_last_cmd,  n_last_cmd;
    logic [3:0]        r_last_ch,   n_last_ch;
    logic [1:0]        r_voice_len, n_voice_len;
    logic [LEN_BITS-1:0] r_remain,  n_remain;
    logic [LEN_BITS-1:0] r_len_acc, n_len_acc;
    logic [7:0]        r_held_type, n_held_type;

    logic                b_hi;
    logic [2:0]          w_cmd;
    logic [1:0]          w_vlen;
    logic [1:0]          w_run_left;
    logic [LEN_BITS-1:0] w_len_push;
    logic [LEN_BITS-1:0] w_remain_dec;
    logic [EXT_BITS-1:0] w_push_ext;
    mtep_pkg::t_result   w_res;

    assign b_hi         = i_track_byte[7];
    assign w_cmd        = i_track_byte[6:4] + 3'd1;
    assign w_vlen       = (w_cmd == mtep_pkg::CMD_PROGRAM ||
                           w_cmd == mtep_pkg::CMD_PRESSURE) ? 2'd1 : 2'd2;
    assign w_run_left   = r_voice_len - 2'd1;
    assign w_remain_dec = r_remain - LEN_BITS'(1);
    assign w_len_push   = (|r_len_acc[LEN_BITS-1 -: 7]) ? '1 :
                          {r_len_acc[LEN_BITS-8:0], i_track_byte[6:0]};
    assign w_push_ext   = EXT_BITS'(w_len_push);

    always_comb begin
        n_phase     = r_phase;
        n_last_cmd  = r_last_cmd;
        n_last_ch   = r_last_ch;
        n_voice_len = r_voice_len;
        n_remain    = r_remain;
        n_len_acc   = r_len_acc;
        n_held_type = r_held_type;
        w_res       = '0;

        if (i_restart) begin
            n_phase     = mtep_pkg::PH_DELTA;
            n_last_cmd  = '0;
            n_last_ch   = '0;
            n_voice_len = '0;
            n_remain    = '0;
            n_len_acc   = '0;
            n_held_type = '0;
        end else begin
            unique case (r_phase)
                mtep_pkg::PH_DELTA: begin
                    if (!b_hi) begin
                        n_phase = mtep_pkg::PH_CMD;
                    end
                end
                mtep_pkg::PH_CMD: begin
                    if (b_hi && i_track_byte[6:4] != 3'b111) begin
                        n_last_cmd  = w_cmd;
                        n_last_ch   = i_track_byte[3:0];
                        n_voice_len = w_vlen;
                        n_remain    = LEN_BITS'(w_vlen);
                        n_phase     = mtep_pkg::PH_VOICE_DATA;
                        w_res.event_start     = 1'b1;
                        w_res.event_class     = mtep_pkg::CLASS_VOICE;
                        w_res.channel         = i_track_byte[3:0];
                        w_res.voice_command   = w_cmd;
                        w_res.declared_length = mtep_pkg::OUT_LEN_BITS'(w_vlen);
                        w_res.event_time      = i_event_time;
                    end else if (b_hi) begin
                        n_voice_len = '0;
                        unique case (i_track_byte) inside
                            [mtep_pkg::ST_RT_FIRST:mtep_pkg::ST_RT_LAST]: begin
                                n_phase = mtep_pkg::PH_DELTA;
                            end
                            mtep_pkg::ST_SYSEX, mtep_pkg::ST_SYSEX_ESC: begin
                                n_last_cmd  = '0;
                                n_held_type = i_track_byte;
                                n_len_acc   = '0;
                                n_phase     = mtep_pkg::PH_SYSEX_LEN;
                            end
                            mtep_pkg::ST_META: begin
                                n_last_cmd = '0;
                                n_phase    = mtep_pkg::PH_META_TYPE;
                            end
                            mtep_pkg::ST_SONG_POS: begin
                                n_last_cmd = '0;
                                n_remain   = LEN_BITS'(2);
                                n_phase    = mtep_pkg::PH_SKIP;
                            end
                            mtep_pkg::ST_SONG_SEL: begin
                                n_last_cmd = '0;
                                n_remain   = LEN_BITS'(1);
                                n_phase    = mtep_pkg::PH_SKIP;
                            end
                            default: begin
                                n_last_cmd = '0;
                                n_phase    = mtep_pkg::PH_DELTA;
                            end
                        endcase
                    end else if (r_voice_len != 2'd0 && r_last_cmd != 3'd0) begin
                        w_res.event_start     = 1'b1;
                        w_res.event_class     = mtep_pkg::CLASS_RUNNING;
                        w_res.channel         = r_last_ch;
                        w_res.voice_command   = r_last_cmd;
                        w_res.declared_length = mtep_pkg::OUT_LEN_BITS'(r_voice_len);
                        w_res.event_time      = i_event_time;
                        w_res.data_valid      = 1'b1;
                        w_res.data_byte       = i_track_byte;
                        w_res.data_last       = (w_run_left == 2'd0);
                        n_remain = LEN_BITS'(w_run_left);
                        n_phase  = (w_run_left == 2'd0) ? mtep_pkg::PH_DELTA :
                                                          mtep_pkg::PH_VOICE_DATA;
                    end
                end
                mtep_pkg::PH_VOICE_DATA, mtep_pkg::PH_BULK_DATA: begin
                    if ((b_hi && r_phase == mtep_pkg::PH_VOICE_DATA) ||
                        r_remain == '0) begin
                        n_phase = mtep_pkg::PH_ERROR;
                    end else begin
                        n_remain         = w_remain_dec;
                        w_res.data_valid = 1'b1;
                        w_res.data_byte  = i_track_byte;
                        w_res.data_last  = (w_remain_dec == '0);
                        if (w_remain_dec == '0) begin
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                    end
                end
                mtep_pkg::PH_SKIP: begin
                    if (b_hi || r_remain == '0) begin
                        n_phase = mtep_pkg::PH_ERROR;
                    end else begin
                        n_remain = w_remain_dec;
                        if (w_remain_dec == '0) begin
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                    end
                end
                mtep_pkg::PH_SYSEX_LEN, mtep_pkg::PH_META_LEN: begin
                    n_len_acc = w_len_push;
                    if (!b_hi) begin
                        n_remain = w_len_push;
                        n_phase  = (w_len_push != '0) ? mtep_pkg::PH_BULK_DATA :
                                                        mtep_pkg::PH_DELTA;
                        if (w_len_push != '0 || r_phase == mtep_pkg::PH_META_LEN) begin
                            w_res.event_start     = 1'b1;
                            w_res.event_class     = (r_phase == mtep_pkg::PH_META_LEN) ?
                                                    mtep_pkg::CLASS_META :
                                                    mtep_pkg::CLASS_SYSEX;
                            w_res.type_byte       = r_held_type;
                            w_res.declared_length =
                                w_push_ext[mtep_pkg::OUT_LEN_BITS-1:0];
                            w_res.event_time      = i_event_time;
                        end
                    end
                end
                mtep_pkg::PH_META_TYPE: begin
                    n_held_type = i_track_byte;
                    n_len_acc   = '0;
                    n_phase     = mtep_pkg::PH_META_LEN;
                end
                mtep_pkg::PH_ERROR: begin
                    n_phase = mtep_pkg::PH_ERROR;
                end
                default: begin
                    n_phase = mtep_pkg::PH_ERROR;
                end
            endcase
            w_res.parse_error = (n_phase == mtep_pkg::PH_ERROR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mtep_pkg::PH_DELTA;
            r_last_cmd  <= '0;
            r_last_ch   <= '0;
            r_voice_len <= '0;
            r_remain    <= '0;
            r_len_acc   <= '0;
            r_held_type <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_last_cmd  <= n_last_cmd;
            r_last_ch   <= n_last_ch;
            r_voice_len <= n_voice_len;
            r_remain    <= n_remain;
            r_len_acc   <= n_len_acc;
            r_held_type <= n_held_type;
        end
    end

    assign o_time_ctl.advance = i_step && !i_restart && (r_phase == mtep_pkg::PH_DELTA);
    assign o_time_ctl.clear   = i_step && i_restart;
    assign o_result           = w_res;

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_ERROR && !(i_step && i_restart))
        |=> (r_phase == mtep_pkg::PH_ERROR))
        else $error("parse error cleared without a new track");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_restart) |=> (r_phase == mtep_pkg::PH_DELTA && r_remain == '0 &&
                                   r_voice_len == 2'd0))
        else $error("new track did not clear parser state");

    a_voice_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_VOICE_DATA) |-> (r_voice_len != 2'd0 && r_remain != '0))
        else $error("voice data phase without a byte count");

endmodule
`default_nettype wire

FILE: src/midi_track_event_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses a standard MIDI file track chunk one byte per transaction.
//
// Input channel: i_valid / o_stall with i_kind and i_track_byte. Kind 1
// starts a new track and clears the parser and the absolute time; kind 0
// feeds the next chunk byte. Output channel: o_valid / i_stall with one
// result per input transaction: event start and fields, data byte with last
// marker, and the sticky parse error.
// A byte taken into the input register has its result loaded into the result
// register once that register is empty or the receiver takes its result.
// Throughput: one byte per cycle while the receiver does not stall; the
// whole phase update and decode sits between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; o_stall rises only when both are full.
// Reset clears both valid flags, the parse phase and the track time.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int TIME_BITS = 32,
    parameter int LEN_BITS  = 28
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_track_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_event_start,
    output logic [1:0]  o_event_class,
    output logic [3:0]  o_channel,
    output logic [2:0]  o_voice_command,
    output logic [7:0]  o_type_byte,
    output logic [27:0] o_declared_length,
    output logic [31:0] o_event_time,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_data_last,
    output logic        o_parse_error
);

    logic              r_in_valid;
    logic              r_in_kind;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    mtep_pkg::t_result r_out;

    logic                                w_adv;
    logic [mtep_pkg::OUT_TIME_BITS-1:0]  w_event_time;
    mtep_pkg::t_time_ctl                 w_time_ctl;
    mtep_pkg::t_result                   w_result;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;

    mtep_time_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_time_ctl),
        .i_track_byte (r_in_byte),
        .o_event_time (w_event_time)
    );

    mtep_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_restart    (r_in_kind),
        .i_track_byte (r_in_byte),
        .i_event_time (w_event_time),
        .o_time_ctl   (w_time_ctl),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_track_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_start     = r_out.event_start;
    assign o_event_class     = r_out.event_class;
    assign o_channel         = r_out.channel;
    assign o_voice_command   = r_out.voice_command;
    assign o_type_byte       = r_out.type_byte;
    assign o_declared_length = r_out.declared_length;
    assign o_event_time      = r_out.event_time;
    assign o_data_valid      = r_out.data_valid;
    assign o_data_byte       = r_out.data_byte;
    assign o_data_last       = r_out.data_last;
    assign o_parse_error     = r_out.parse_error;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_valid)
        else $error("advanced transaction produced no result");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result register could take data");

    a_held_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_kind)))
        else $error("held input transaction was lost");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds track bytes and begin-track transactions through the valid/stall
// input channel and predicts one result per transaction with a behavioral
// parser model kept in step at acceptance. Each result taken from the output
// channel is compared field by field with the oldest prediction. Directed
// sequences cover voice and running status, system bytes, time and count
// saturation and the sticky error; random well-formed tracks with injected
// noise follow under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import mtep_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [63:0] TIME_MASK   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LEN_MASK    = 64'h0000_0000_0FFF_FFFF;

    localparam logic [7:0] ST_QFRAME   = 8'hF1;
    localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
    localparam logic [7:0] ST_TUNE_REQ = 8'hF6;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_kind       = 1'b0;
    logic [7:0]  i_track_byte = 8'h00;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_event_start;
    logic [1:0]  o_event_class;
    logic [3:0]  o_channel;
    logic [2:0]  o_voice_command;
    logic [7:0]  o_type_byte;
    logic [27:0] o_declared_length;
    logic [31:0] o_event_time;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic        o_data_last;
    logic        o_parse_error;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int live_items   = 0;
    int result_cnt   = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    t_result expected_q[$];
    t_result next_result;
    t_result got_r;
    t_result want_r;

    t_phase      parse_phase;
    logic [63:0] delta_acc;
    logic [63:0] trk_time;
    logic [63:0] remaining;
    logic [63:0] len_acc;
    logic [2:0]  run_cmd;
    logic [3:0]  run_chan;
    logic [1:0]  run_len;
    logic [7:0]  hold_type;

    midi_track_event_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_track_byte      (i_track_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_start     (o_event_start),
        .o_event_class     (o_event_class),
        .o_channel         (o_channel),
        .o_voice_command   (o_voice_command),
        .o_type_byte       (o_type_byte),
        .o_declared_length (o_declared_length),
        .o_event_time      (o_event_time),
        .o_data_valid      (o_data_valid),
        .o_data_byte       (o_data_byte),
        .o_data_last       (o_data_last),
        .o_parse_error     (o_parse_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_track();
        parse_phase = PH_DELTA;
        delta_acc   = '0;
        trk_time    = '0;
        remaining   = '0;
        len_acc     = '0;
        run_cmd     = '0;
        run_chan    = '0;
        run_len     = '0;
        hold_type   = '0;
    endfunction

    function automatic void enter_delta();
        parse_phase = PH_DELTA;
        delta_acc   = '0;
    endfunction

    function automatic logic [63:0] vlq_shift(input logic [63:0] acc, input logic [7:0] b,
                                              input logic [63:0] mask);
        if (acc > (mask >> 7)) begin
            return mask;
        end
        return (acc << 7) | {57'd0, b[6:0]};
    endfunction

    function automatic void open_event(input logic [1:0] cls, input logic [3:0] chan,
                                       input logic [2:0] cmd, input logic [7:0] typ,
                                       input logic [63:0] len);
        next_result.event_start     = 1'b1;
        next_result.event_class     = cls;
        next_result.channel         = chan;
        next_result.voice_command   = cmd;
        next_result.type_byte       = typ;
        next_result.declared_length = len[27:0];
        next_result.event_time      = trk_time[31:0];
    endfunction

    function automatic void take_data(input logic [7:0] b);
        remaining              = remaining - 64'd1;
        next_result.data_valid = 1'b1;
        next_result.data_byte  = b;
        next_result.data_last  = (remaining == 64'd0);
        if (remaining == 64'd0) begin
            enter_delta();
        end
    endfunction

    function automatic void predict_byte(input logic kind, input logic [7:0] b);
        logic [63:0] sum;
        next_result = '0;
        if (kind) begin
            clear_track();
            return;
        end
        case (parse_phase)
            PH_DELTA: begin
                delta_acc = vlq_shift(delta_acc, b, TIME_MASK);
                if (!b[7]) begin
                    sum         = trk_time + delta_acc;
                    trk_time    = (sum > TIME_MASK) ? TIME_MASK : sum;
                    parse_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (b[7]) begin
                    if (b < ST_SYSEX) begin
                        run_cmd     = b[6:4] + 3'd1;
                        run_chan    = b[3:0];
                        run_len     = (run_cmd == CMD_PROGRAM || run_cmd == CMD_PRESSURE)
                                      ? 2'd1 : 2'd2;
                        remaining   = {62'd0, run_len};
                        parse_phase = PH_VOICE_DATA;
                        open_event(CLASS_VOICE, run_chan, run_cmd, 8'h00, {62'd0, run_len});
                    end else begin
                        run_len = 2'd0;
                        if (b >= ST_RT_FIRST && b <= ST_RT_LAST) begin
                            enter_delta();
                        end else begin
                            run_cmd = 3'd0;
                            if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                                hold_type   = b;
                                len_acc     = '0;
                                parse_phase = PH_SYSEX_LEN;
                            end else if (b == ST_META) begin
                                parse_phase = PH_META_TYPE;
                            end else if (b == ST_SONG_POS || b == ST_SONG_SEL) begin
                                remaining   = (b == ST_SONG_POS) ? 64'd2 : 64'd1;
                                parse_phase = PH_SKIP;
                            end else begin
                                enter_delta();
                            end
                        end
                    end
                end else if (run_len != 2'd0 && run_cmd != 3'd0) begin
                    open_event(CLASS_RUNNING, run_chan, run_cmd, 8'h00, {62'd0, run_len});
                    remaining   = {62'd0, run_len};
                    parse_phase = PH_VOICE_DATA;
                    take_data(b);
                end
            end
            PH_VOICE_DATA: begin
                if (b[7] || remaining == 64'd0) begin
                    parse_phase = PH_ERROR;
                end else begin
                    take_data(b);
                end
            end
            PH_SKIP: begin
                if (b[7] || remaining == 64'd0) begin
                    parse_phase = PH_ERROR;
                end else begin
                    remaining = remaining - 64'd1;
                    if (remaining == 64'd0) begin
                        enter_delta();
                    end
                end
            end
            PH_SYSEX_LEN: begin
                len_acc = vlq_shift(len_acc, b, LEN_MASK);
                if (!b[7]) begin
                    if (len_acc != 64'd0) begin
                        open_event(CLASS_SYSEX, 4'd0, 3'd0, hold_type, len_acc);
                        remaining   = len_acc;
                        parse_phase = PH_BULK_DATA;
                    end else begin
                        enter_delta();
                    end
                end
            end
            PH_META_TYPE: begin
                hold_type   = b;
                len_acc     = '0;
                parse_phase = PH_META_LEN;
            end
            PH_META_LEN: begin
                len_acc = vlq_shift(len_acc, b, LEN_MASK);
                if (!b[7]) begin
                    open_event(CLASS_META, 4'd0, 3'd0, hold_type, len_acc);
                    remaining = len_acc;
                    if (len_acc != 64'd0) begin
                        parse_phase = PH_BULK_DATA;
                    end else begin
                        enter_delta();
                    end
                end
            end
            PH_BULK_DATA: begin
                if (remaining == 64'd0) begin
                    parse_phase = PH_ERROR;
                end else begin
                    take_data(b);
                end
            end
            default: begin
                parse_phase = PH_ERROR;
            end
        endcase
        next_result.parse_error = (parse_phase == PH_ERROR);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) begin
            $display("result %0d: %s got 0x%0h, want 0x%0h", result_cnt, what, got, want);
        end
    endtask

    task automatic send_byte(input logic kind, input logic [7:0] b);
        t_phase prior;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_track_byte <= b;
        do @(posedge i_clk); while (o_stall);
        prior = parse_phase;
        predict_byte(kind, b);
        expected_q.push_back(next_result);
        if (kind || prior != PH_ERROR) begin
            live_items++;
        end
    endtask

    task automatic send_count();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'h80 | 8'($urandom_range(0, 127)));
        end
        send_byte(1'b0, 8'($urandom_range(0, 6)));
    endtask

    task automatic send_random_event();
        int pick;
        int nbytes;
        int fed;
        pick   = $urandom_range(0, 99);
        nbytes = (pick < 60) ? 1 : (pick < 85) ? 2 : (pick < 95) ? 4 : 5;
        repeat (nbytes - 1) send_byte(1'b0, 8'h80 | 8'($urandom_range(0, 127)));
        send_byte(1'b0, 8'($urandom_range(0, 127)));
        do begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_byte(1'b0, 8'($urandom_range(8'h80, 8'hEF)));
            end else if (pick < 55) begin
                send_byte(1'b0, 8'($urandom_range(0, 127)));
            end else if (pick < 67) begin
                send_byte(1'b0, ST_META);
                send_byte(1'b0, 8'($urandom_range(0, 255)));
                send_count();
            end else if (pick < 77) begin
                send_byte(1'b0, ($urandom_range(0, 1) != 0) ? ST_SYSEX : ST_SYSEX_ESC);
                send_count();
            end else if (pick < 85) begin
                send_byte(1'b0, 8'($urandom_range(ST_RT_FIRST, ST_RT_LAST)));
            end else if (pick < 91) begin
                case ($urandom_range(0, 3))
                    0:       send_byte(1'b0, ST_QFRAME);
                    1:       send_byte(1'b0, ST_UNDEF_F4);
                    2:       send_byte(1'b0, ST_UNDEF_F5);
                    default: send_byte(1'b0, ST_TUNE_REQ);
                endcase
            end else if (pick < 97) begin
                send_byte(1'b0, ($urandom_range(0, 1) != 0) ? ST_SONG_POS : ST_SONG_SEL);
            end else begin
                send_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            while (parse_phase == PH_VOICE_DATA || parse_phase == PH_SKIP) begin
                if ($urandom_range(0, 99) < 3) begin
                    send_byte(1'b0, 8'($urandom_range(128, 255)));
                end else begin
                    send_byte(1'b0, 8'($urandom_range(0, 127)));
                end
            end
            fed = 0;
            while (parse_phase == PH_BULK_DATA) begin
                send_byte(fed == 8, 8'($urandom_range(0, 255)));
                fed++;
            end
        end while (parse_phase == PH_CMD);
    endtask

    task automatic test_begin_and_voice();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h9F, 8'h00, 8'h7F, 8'h00, 8'h7F, 8'h00};
        send_byte(1'b1, 8'hFF);
        foreach (seq[i]) send_byte(1'b0, seq[i]);
    endtask

    task automatic test_system_bytes();
        logic [7:0] seq[$];
        seq = '{8'h00, ST_RT_FIRST, 8'h00, 8'h40, ST_SONG_SEL, 8'h05,
                8'h00, ST_META, 8'h2F, 8'h00, 8'h00, ST_SYSEX, 8'h00};
        foreach (seq[i]) send_byte(1'b0, seq[i]);
    endtask

    task automatic test_time_saturation();
        logic [7:0] seq[$];
        seq = '{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, ST_TUNE_REQ,
                8'h01, ST_META, 8'h00, 8'h00};
        foreach (seq[i]) send_byte(1'b0, seq[i]);
    endtask

    task automatic test_length_saturation();
        logic [7:0] seq[$];
        seq = '{8'h00, ST_SYSEX_ESC, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80};
        foreach (seq[i]) send_byte(1'b0, seq[i]);
        send_byte(1'b1, 8'h00);
    endtask

    task automatic test_error_sticky();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'hC5, 8'h90, 8'h12};
        foreach (seq[i]) send_byte(1'b0, seq[i]);
    endtask

    task automatic test_random_tracks(input int n_items);
        int stop_at;
        stop_at = live_items + n_items;
        send_byte(1'b1, 8'($urandom_range(0, 255)));
        while (live_items < stop_at) begin
            if (parse_phase == PH_ERROR || $urandom_range(0, 59) == 0) begin
                send_byte(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                send_random_event();
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_r = {o_event_start, o_event_class, o_channel, o_voice_command, o_type_byte,
                     o_declared_length, o_event_time, o_data_valid, o_data_byte,
                     o_data_last, o_parse_error};
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, parse_error", 32'(got_r.parse_error), 32'd0);
            end else begin
                want_r = expected_q.pop_front();
                if (got_r.event_start != want_r.event_start)
                    report_mismatch("event_start", 32'(got_r.event_start),
                                    32'(want_r.event_start));
                if (got_r.event_class != want_r.event_class)
                    report_mismatch("event_class", 32'(got_r.event_class),
                                    32'(want_r.event_class));
                if (got_r.channel != want_r.channel)
                    report_mismatch("channel", 32'(got_r.channel), 32'(want_r.channel));
                if (got_r.voice_command != want_r.voice_command)
                    report_mismatch("voice_command", 32'(got_r.voice_command),
                                    32'(want_r.voice_command));
                if (got_r.type_byte != want_r.type_byte)
                    report_mismatch("type_byte", 32'(got_r.type_byte), 32'(want_r.type_byte));
                if (got_r.declared_length != want_r.declared_length)
                    report_mismatch("declared_length", 32'(got_r.declared_length),
                                    32'(want_r.declared_length));
                if (got_r.event_time != want_r.event_time)
                    report_mismatch("event_time", got_r.event_time, want_r.event_time);
                if (got_r.data_valid != want_r.data_valid)
                    report_mismatch("data_valid", 32'(got_r.data_valid),
                                    32'(want_r.data_valid));
                if (got_r.data_byte != want_r.data_byte)
                    report_mismatch("data_byte", 32'(got_r.data_byte), 32'(want_r.data_byte));
                if (got_r.data_last != want_r.data_last)
                    report_mismatch("data_last", 32'(got_r.data_last), 32'(want_r.data_last));
                if (got_r.parse_error != want_r.parse_error)
                    report_mismatch("parse_error", 32'(got_r.parse_error),
                                    32'(want_r.parse_error));
            end
            result_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        clear_track();
        tx_idle_pct = 14;
        rx_idle_pct = 46;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_begin_and_voice();
        test_system_bytes();
        test_time_saturation();
        test_length_saturation();
        test_error_sticky();
        test_random_tracks(380);

        tx_idle_pct = 46;
        rx_idle_pct = 14;
        test_random_tracks(380);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_tracks(360);

        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mtep_pkg.sv
src/mtep_time_unit.sv
src/mtep_core.sv
src/midi_track_event_parser.sv
dv/tb_top.sv
